// ----- rtl/bpe_pkg.sv -----
// Shared types and constants for the button press and chord encoder.
package bpe_pkg;

  localparam int MAX_BUTTONS = 7;
  localparam int TICK_W      = 16;
  localparam int MSG_W       = 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [TICK_W-1:0]      LONG_TICKS_RST = 16'd20;
  localparam logic [MAX_BUTTONS-1:0] ACT_MASK_RST   = 7'h01;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_TICKS  = 2'd0,
    REG_ACTIVE_MASK = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BS_REL  = 2'd0,
    BS_HELD = 2'd1,
    BS_LONG = 2'd2
  } btn_state_t;

  typedef enum int unsigned {
    MSG_COMBO    = 0,
    MSG_TUNING   = 1,
    MSG_EFFECT   = 2,
    MSG_SHUTDOWN = 7
  } msg_bit_t;

  typedef struct packed {
    logic down_old;
    logic down_new;
    logic rel_held;
    logic long_held;
  } lane_stat_t;

endpackage

// ----- rtl/bpe_lane.sv -----
// Per-button lane: edge detection, hold tick counter and button state.
module bpe_lane
  import bpe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic              lvl,
  input  logic              act,
  input  logic              rst_level,
  input  logic [TICK_W-1:0] long_ticks,
  output lane_stat_t        stat
);

  btn_state_t        state_r, state_nxt;
  logic              last_r;
  logic [TICK_W-1:0] ticks_r, ticks_nxt;
  logic [TICK_W:0]   ticks_sum;
  logic [TICK_W-1:0] ticks_inc;
  logic              pin_edge, press, release_ev, long_ev;

  always_comb begin
    pin_edge   = lvl != last_r;
    press      = pin_edge && (lvl == act);
    release_ev = pin_edge && (lvl != act);
    ticks_sum  = {1'b0, ticks_r} + {{TICK_W{1'b0}}, 1'b1};
    ticks_inc  = (ticks_r == {TICK_W{1'b1}}) ? ticks_r : ticks_sum[TICK_W-1:0];
    long_ev    = !pin_edge && (state_r == BS_HELD) && (ticks_inc > long_ticks);

    state_nxt = state_r;
    ticks_nxt = ticks_r;
    unique case (state_r)
      BS_REL: begin
        if (press) begin
          state_nxt = BS_HELD;
          ticks_nxt = '0;
        end
      end
      BS_HELD: begin
        if (!pin_edge) begin
          ticks_nxt = ticks_inc;
        end
        if (release_ev) begin
          state_nxt = BS_REL;
        end else if (long_ev) begin
          state_nxt = BS_LONG;
        end
      end
      BS_LONG: begin
        if (release_ev) begin
          state_nxt = BS_REL;
        end
      end
      default: begin
        state_nxt = BS_REL;
      end
    endcase

    stat.down_old  = state_r != BS_REL;
    stat.down_new  = state_nxt != BS_REL;
    stat.rel_held  = (state_r == BS_HELD) && release_ev;
    stat.long_held = long_ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_REL;
      last_r  <= rst_level;
      ticks_r <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      last_r  <= lvl;
      ticks_r <= ticks_nxt;
    end
  end

endmodule

// ----- rtl/bpe_merge.sv -----
// Merges the lane results into the message mask and the held mask.
module bpe_merge
  import bpe_pkg::*;
(
  input  lane_stat_t             stat [MAX_BUTTONS],
  output logic [MSG_W-1:0]       msg,
  output logic [MAX_BUTTONS-1:0] held
);

  logic others_down;

  always_comb begin
    msg         = '0;
    others_down = 1'b0;
    for (int i = 1; i < MAX_BUTTONS; i++) begin
      others_down = others_down | stat[i].down_old;
    end
    for (int i = 3; i < MAX_BUTTONS; i++) begin
      msg[i] = stat[i].rel_held;
    end
    msg[MSG_TUNING]   = stat[1].rel_held;
    msg[MSG_EFFECT]   = stat[2].rel_held && !stat[0].down_new;
    msg[MSG_COMBO]    = (stat[0].rel_held && stat[2].down_old) ||
                        (stat[2].rel_held && stat[0].down_new);
    msg[MSG_SHUTDOWN] = stat[0].long_held && !others_down;
    for (int i = 0; i < MAX_BUTTONS; i++) begin
      held[i] = stat[i].down_new;
    end
  end

endmodule

// ----- rtl/button_press_chord_long_press_encoder.sv -----
// Top level of the button press, long press and chord encoder.
//
//   Port group   Direction  Handshake           Payload
//   in_          input      in_valid/in_stall   in_pin_levels
//   out_         output     out_valid/out_stall out_message_mask, out_held_mask
//   cfg_         input      cfg_valid/cfg_ready cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; each lane updates its button
// at the accepting edge, which also registers the result in the output or skid register.
// A skid register holds one further result, so in_stall rises only when it is full.
// Synchronous reset clears states, ticks and valid flags and sets each pin history inactive.
// Configuration writes are taken in every cycle.
module button_press_chord_long_press_encoder
  import bpe_pkg::*;
#(
  parameter int NUM_BUTTONS = 7
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [MAX_BUTTONS-1:0] in_pin_levels,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MSG_W-1:0]       out_message_mask,
  output logic [MAX_BUTTONS-1:0] out_held_mask,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [TICK_W-1:0]      long_ticks_r;
  logic [MAX_BUTTONS-1:0] act_mask_r;
  lane_stat_t             stat [MAX_BUTTONS];
  logic [MSG_W-1:0]       msg;
  logic [MAX_BUTTONS-1:0] held;
  logic                   accept, out_fire;
  logic                   out_valid_r, skid_valid_r;
  logic [MSG_W-1:0]       out_msg_r, skid_msg_r;
  logic [MAX_BUTTONS-1:0] out_held_r, skid_held_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_TICKS_RST;
      act_mask_r   <= ACT_MASK_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_LONG_TICKS) begin
        long_ticks_r <= cfg_data[TICK_W-1:0];
      end else if (cfg_index == REG_ACTIVE_MASK) begin
        act_mask_r <= cfg_data[MAX_BUTTONS-1:0];
      end
    end
  end

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid_r;

  for (genvar g = 0; g < MAX_BUTTONS; g++) begin : g_lane
    if (g < NUM_BUTTONS) begin : g_on
      bpe_lane u_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (accept),
        .lvl        (in_pin_levels[g]),
        .act        (act_mask_r[g]),
        .rst_level  (!ACT_MASK_RST[g]),
        .long_ticks (long_ticks_r),
        .stat       (stat[g])
      );
    end else begin : g_off
      assign stat[g] = '0;
    end
  end

  bpe_merge u_merge (
    .stat (stat),
    .msg  (msg),
    .held (held)
  );

  assign out_fire = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_msg_r  <= skid_msg_r;
        out_held_r <= skid_held_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_fire) begin
        skid_msg_r  <= msg;
        skid_held_r <= held;
      end else begin
        out_msg_r  <= msg;
        out_held_r <= held;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_message_mask = out_msg_r;
  assign out_held_mask    = out_held_r;

endmodule

// ----- test/button_press_chord_long_press_encoder_tb.sv -----
// Self-checking testbench for the button press, long press and chord encoder.
`timescale 1ns / 100ps

module button_press_chord_long_press_encoder_tb;
  import bpe_pkg::*;

  localparam int NBTN      = 7;
  localparam int BTN_ONE   = 0;
  localparam int BTN_THREE = 2;
  localparam int LIMIT     = 400000;
  localparam int LONG_HOLD = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef enum logic [1:0] {
    PE_NONE,
    PE_PRESS,
    PE_RELEASE,
    PE_LONG
  } poll_event_t;

  typedef enum logic {
    ROW_POLL,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    logic [MAX_BUTTONS-1:0]  pins;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    typed;
    logic [MSG_W-1:0]        msg;
    logic [MAX_BUTTONS-1:0]  held;
  } plan_row_t;

  typedef struct {
    logic [MSG_W-1:0]       msg;
    logic [MAX_BUTTONS-1:0] held;
  } poll_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [MAX_BUTTONS-1:0] in_pin_levels = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MSG_W-1:0]       out_message_mask;
  logic [MAX_BUTTONS-1:0] out_held_mask;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  btn_state_t             btn_st [MAX_BUTTONS];
  logic                   pin_seen [MAX_BUTTONS];
  logic [TICK_W-1:0]      hold_cnt [MAX_BUTTONS];
  logic [TICK_W-1:0]      long_limit;
  logic [MAX_BUTTONS-1:0] active_lvl;

  poll_result_t pending_polls [$];
  int           errors = 0;
  int           cycles = 0;
  int           stall_left = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;

  plan_row_t script [31] = '{
    '{ROW_POLL, 7'h7E, REG_LONG_TICKS,  16'h0000, 1'b1, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7B, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7A, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7B, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7E, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7A, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7E, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h01, REG_LONG_TICKS,  16'h0000, 1'b1, 8'h00, 7'h7F},
    '{ROW_POLL, 7'h7E, REG_LONG_TICKS,  16'h0000, 1'b1, 8'h7F, 7'h00},
    '{ROW_CFG,  7'h00, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b1, 8'h80, 7'h01},
    '{ROW_POLL, 7'h7E, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7D, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7D, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7E, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_CFG,  7'h00, REG_ACTIVE_MASK, 16'hFF7F, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h00, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_CFG,  7'h00, REG_SPARE_A,     16'hFFFF, 1'b0, 8'h00, 7'h00},
    '{ROW_CFG,  7'h00, REG_SPARE_B,     16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h00, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_CFG,  7'h00, REG_LONG_TICKS,  16'hFFFE, 1'b0, 8'h00, 7'h00},
    '{ROW_CFG,  7'h00, REG_ACTIVE_MASK, 16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h00, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h2A, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00},
    '{ROW_POLL, 7'h7F, REG_LONG_TICKS,  16'h0000, 1'b0, 8'h00, 7'h00}
  };

  button_press_chord_long_press_encoder #(
    .NUM_BUTTONS(NBTN)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_message_mask (out_message_mask),
    .out_held_mask    (out_held_mask),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit btn_down(input int b);
    return (b < NBTN) && (btn_st[b] != BS_REL);
  endfunction

  function automatic logic [MAX_BUTTONS-1:0] pins_for(input logic [MAX_BUTTONS-1:0] pressed);
    return ~(pressed ^ active_lvl);
  endfunction

  // Events are found for every button first, then applied in button order.
  function automatic void predict_poll(input logic [MAX_BUTTONS-1:0] pins,
                                       output logic [MSG_W-1:0] msg,
                                       output logic [MAX_BUTTONS-1:0] held);
    poll_event_t ev [MAX_BUTTONS];
    bit          alone;
    msg  = '0;
    held = '0;
    for (int b = 0; b < NBTN; b++) begin
      ev[b] = PE_NONE;
      if (pins[b] != pin_seen[b]) begin
        ev[b] = (pins[b] == active_lvl[b]) ? PE_PRESS : PE_RELEASE;
        pin_seen[b] = pins[b];
      end else if (btn_st[b] == BS_HELD) begin
        if (hold_cnt[b] != '1) hold_cnt[b] = hold_cnt[b] + 1'b1;
        if (hold_cnt[b] > long_limit) ev[b] = PE_LONG;
      end
    end
    for (int b = 0; b < NBTN; b++) begin
      case (btn_st[b])
        BS_REL: begin
          if (ev[b] == PE_PRESS) begin
            hold_cnt[b] = '0;
            btn_st[b] = BS_HELD;
          end
        end
        BS_HELD: begin
          if (ev[b] == PE_RELEASE) begin
            if (b == BTN_ONE) begin
              if (btn_down(BTN_THREE)) msg[MSG_COMBO] = 1'b1;
            end else if (b == BTN_THREE) begin
              if (btn_down(BTN_ONE)) msg[MSG_COMBO] = 1'b1;
              else msg[MSG_EFFECT] = 1'b1;
            end else begin
              // The other buttons each own the message bit at their index.
              msg[b] = 1'b1;
            end
            btn_st[b] = BS_REL;
          end else if (ev[b] == PE_LONG) begin
            alone = 1'b1;
            for (int k = 1; k < NBTN; k++) if (btn_down(k)) alone = 1'b0;
            if (b == BTN_ONE && alone) msg[MSG_SHUTDOWN] = 1'b1;
            btn_st[b] = BS_LONG;
          end
        end
        default: begin
          if (ev[b] == PE_RELEASE) btn_st[b] = BS_REL;
        end
      endcase
    end
    for (int b = 0; b < NBTN; b++) held[b] = btn_down(b);
  endfunction

  task automatic send_poll(input logic [MAX_BUTTONS-1:0] pins, input logic typed,
                           input logic [MSG_W-1:0] t_msg,
                           input logic [MAX_BUTTONS-1:0] t_held);
    poll_result_t res;
    cfg_valid <= 1'b0;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pin_levels <= pins;
    do @(posedge clk); while (in_stall);
    predict_poll(pins, res.msg, res.held);
    if (typed) begin
      res.msg  = t_msg;
      res.held = t_held;
    end
    pending_polls.push_back(res);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_polls.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_LONG_TICKS) long_limit = data;
    else if (idx == REG_ACTIVE_MASK) active_lvl = data[MAX_BUTTONS-1:0];
  endtask

  always @(posedge clk) begin
    if (!stalls_on) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_stall  <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    poll_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_polls.size() == 0) begin
        $error("unexpected item: message_mask %h held_mask %h",
               out_message_mask, out_held_mask);
        errors++;
      end else begin
        want = pending_polls.pop_front();
        if (out_message_mask !== want.msg) begin
          $error("message_mask: expected %h, got %h", want.msg, out_message_mask);
          errors++;
        end
        if (out_held_mask !== want.held) begin
          $error("held_mask: expected %h, got %h", want.held, out_held_mask);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [MAX_BUTTONS-1:0] pressed;
    logic [MAX_BUTTONS-1:0] pins;
    logic [CFG_DATA_W-1:0]  ticks;
    logic [MAX_BUTTONS-1:0] mask;
    int                     btn;

    long_limit = LONG_TICKS_RST;
    active_lvl = ACT_MASK_RST;
    for (int b = 0; b < MAX_BUTTONS; b++) begin
      btn_st[b]   = BS_REL;
      pin_seen[b] = ~ACT_MASK_RST[b];
      hold_cnt[b] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        settle();
        write_reg(script[r].idx, script[r].data);
      end else begin
        send_poll(script[r].pins, script[r].typed, script[r].msg, script[r].held);
      end
    end

    // Each phase keeps the buttons that are down, so a new polarity shows up as edges.
    pressed = '0;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: ticks = 16'd0;
        1: ticks = 16'd1;
        2: ticks = 16'd3;
        3: ticks = LONG_TICKS_RST;
        4: ticks = 16'($urandom_range(0, 40));
        5: ticks = 16'($urandom_range(0, 65534));
        6: ticks = 16'd12;
        7: ticks = 16'($urandom_range(0, 30));
        default: ticks = 16'd5;
      endcase
      case (ph)
        1: mask = 7'h00;
        2: mask = 7'h7F;
        default: mask = 7'($urandom_range(0, 127));
      endcase
      settle();
      write_reg(REG_LONG_TICKS, ticks);
      write_reg(REG_ACTIVE_MASK, {9'($urandom_range(0, 511)), mask});
      gaps_on   = (ph == 0) || ($urandom_range(0, 3) != 0);
      stalls_on = (ph == 0) || ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 145; n++) begin
        if ($urandom_range(0, 9) == 0) begin
          pins    = 7'($urandom_range(0, 127));
          pressed = ~(pins ^ active_lvl);
        end else begin
          if ($urandom_range(0, 2) == 0) begin
            btn = $urandom_range(0, 1) ? 2 * $urandom_range(0, 1) : $urandom_range(0, 6);
            pressed[btn] = ~pressed[btn];
          end
          pins = pins_for(pressed);
        end
        send_poll(pins, 1'b0, '0, '0);
      end
    end

    // A press of button one held well past a short threshold, with no idling.
    settle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    write_reg(REG_LONG_TICKS, 16'd8);
    pressed = '0;
    send_poll(pins_for(pressed), 1'b0, '0, '0);
    pressed[BTN_ONE] = 1'b1;
    for (int n = 0; n < LONG_HOLD; n++) send_poll(pins_for(pressed), 1'b0, '0, '0);
    pressed = '0;
    send_poll(pins_for(pressed), 1'b0, '0, '0);

    settle();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
